/* src/lcdw_pkg.sv */
// Shared types and constants for the character LCD write controller.
package lcdw_pkg;

    // Request mode codes
    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_COMMAND = 3'd1;
    localparam logic [2:0] MODE_DATA    = 3'd2;
    localparam logic [2:0] MODE_CURSOR  = 3'd3;
    localparam logic [2:0] MODE_NUMBER  = 3'd4;
    localparam logic [2:0] MODE_GLYPH   = 3'd5;

    // Configuration register indexes
    localparam logic CFG_STARTUP_WAIT = 1'b0;
    localparam logic CFG_ENABLE_PULSE = 1'b1;

    localparam int unsigned CFG_W = 24;
    localparam logic [CFG_W-1:0] STARTUP_WAIT_RESET = 24'd2000000;
    localparam logic [CFG_W-1:0] ENABLE_PULSE_RESET = 24'd100000;

    // LCD instruction bytes
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_CGRAM_BASE   = 8'h40;
    localparam logic [7:0] DDRAM_LINE0      = 8'h80;
    localparam logic [7:0] DDRAM_LINE1      = 8'hC0;
    localparam logic [7:0] ASCII_ZERO       = 8'h30;

    // Register select codes
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // Number and glyph geometry
    localparam int unsigned NUM_W       = 16;
    localparam int unsigned BCD_DIGITS  = 5;
    localparam int unsigned BCD_W       = 4 * BCD_DIGITS;
    localparam int unsigned GLYPH_SLOTS = 8;
    localparam int unsigned SLOT_W      = $clog2(GLYPH_SLOTS);
    localparam int unsigned ROW_W       = 5;
    localparam int unsigned GLYPH_ROWS  = 8;
    localparam int unsigned GLYPH_W     = ROW_W * GLYPH_ROWS;

    // Transfer index positions inside runs
    localparam logic [3:0] INIT_LAST_IDX  = 4'd2;
    localparam logic [3:0] GLYPH_ADDR_IDX = 4'(GLYPH_ROWS + 1);
    localparam logic [3:0] GLYPH_LAST_IDX = 4'(GLYPH_ROWS + 2);

    // Request queue depth
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_SINGLE,
        JOB_NUMBER,
        JOB_GLYPH
    } job_kind_t;

    // Classified request as held in the queue
    typedef struct packed {
        job_kind_t          kind;
        logic               rs;
        logic [7:0]         byte_val;
        logic [NUM_W-1:0]   number;
        logic [SLOT_W-1:0]  slot;
        logic [7:0]         address;
        logic [GLYPH_W-1:0] rows;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WAIT,
        BK_CONVERT,
        BK_PULSE,
        BK_PUSH
    } back_state_t;

endpackage

/* src/lcdw_ifs.sv */
// Handshake interfaces for request, transfer and configuration channels.
interface lcdw_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  byte_value;
    logic        line_row;
    logic [5:0]  column;
    logic [15:0] number_value;
    logic [2:0]  glyph_slot;
    logic [39:0] glyph_rows;

    modport source (output valid, mode, byte_value, line_row, column, number_value,
                    glyph_slot, glyph_rows, input ready);
    modport sink (input valid, mode, byte_value, line_row, column, number_value,
                  glyph_slot, glyph_rows, output ready);
endinterface

interface lcdw_xfer_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last_of_run;

    modport source (output valid, reg_select, bus_byte, last_of_run, input ready);
    modport sink (input valid, reg_select, bus_byte, last_of_run, output ready);
endinterface

interface lcdw_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/lcdw_front.sv */
// Front end: accepts requests, drops unused modes and classifies the rest into jobs.
module lcdw_front #(
    parameter int unsigned LINE_LENGTH = 40
) (
    lcdw_req_if.sink           req,
    input  lcdw_pkg::q_status_t q_status,
    output logic               push,
    output lcdw_pkg::job_t     entry
);
    import lcdw_pkg::*;

    logic       mode_ok;
    logic [5:0] col_sat;
    logic [7:0] cursor_addr;

    // Take a request whenever the queue has room
    assign req.ready = !q_status.full;
    assign push      = req.valid && req.ready && mode_ok;

    // Cursor address with column clamped to the line length
    always_comb
    begin
        if (req.column >= 6'(LINE_LENGTH))
            col_sat = 6'(LINE_LENGTH - 1);
        else
            col_sat = req.column;
        cursor_addr = (req.line_row ? DDRAM_LINE1 : DDRAM_LINE0) + {2'b00, col_sat};
    end

    // Classify
    always_comb
    begin
        mode_ok        = 1'b1;
        entry.kind     = JOB_SINGLE;
        entry.rs       = RS_INSTR;
        entry.byte_val = req.byte_value;
        entry.number   = req.number_value;
        entry.slot     = req.glyph_slot;
        entry.address  = cursor_addr;
        entry.rows     = req.glyph_rows;
        unique case (req.mode)
            MODE_INIT:    entry.kind = JOB_INIT;
            MODE_COMMAND: entry.kind = JOB_SINGLE;
            MODE_DATA:    entry.rs   = RS_DATA;
            MODE_CURSOR:  entry.byte_val = cursor_addr;
            MODE_NUMBER:  entry.kind = JOB_NUMBER;
            MODE_GLYPH:   entry.kind = JOB_GLYPH;
            default:      mode_ok    = 1'b0;
        endcase
    end

endmodule

/* src/lcdw_queue.sv */
// Short job queue between the front end and the transfer sequencer.
module lcdw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcdw_pkg::job_t      push_entry,
    input  logic                pop,
    output lcdw_pkg::job_t      head,
    output lcdw_pkg::q_status_t status
);
    import lcdw_pkg::*;

    job_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* src/lcdw_back.sv */
// Back end: timing registers, BCD conversion and per-transfer sequencing.
module lcdw_back (
    input  logic                clk,
    input  logic                rst_n,
    lcdw_cfg_if.sink            cfg,
    input  lcdw_pkg::job_t      job,
    input  lcdw_pkg::q_status_t q_status,
    output logic                pop,
    lcdw_xfer_if.source         xfer
);
    import lcdw_pkg::*;

    localparam int unsigned CONV_W = $clog2(NUM_W + 1);

    back_state_t        state_reg, state_next;
    logic [CFG_W-1:0]   startup_wait_reg, enable_pulse_reg;
    logic [CFG_W-1:0]   delay_counter_reg, delay_counter_next;
    logic [3:0]         transfer_index_reg, transfer_index_next;
    logic [CONV_W-1:0]  conv_count_reg, conv_count_next;
    logic [2:0]         digit_count_reg, digit_count_next;
    logic               out_valid_reg, out_valid_next;

    logic [NUM_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_digits_reg, bcd_digits_next;
    logic [GLYPH_W-1:0] glyph_shift_reg, glyph_shift_next;
    logic               out_rs_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    logic [CFG_W-1:0]   pulse_len;
    logic [BCD_W-1:0]   bcd_adj;
    logic [2:0]         bcd_len;
    logic [3:0]         cur_digit;
    logic               cur_rs;
    logic [7:0]         cur_byte;
    logic               cur_last;
    logic               out_free;
    logic               out_load;

    assign cfg.ready   = 1'b1;
    assign pulse_len   = (enable_pulse_reg == '0) ? CFG_W'(1) : enable_pulse_reg;
    assign out_free    = !out_valid_reg || xfer.ready;
    assign out_load    = (state_reg == BK_PUSH) && out_free;
    assign pop         = out_load && cur_last;

    assign xfer.valid       = out_valid_reg;
    assign xfer.reg_select  = out_rs_reg;
    assign xfer.bus_byte    = out_byte_reg;
    assign xfer.last_of_run = out_last_reg;

    // Double-dabble adjust: add 3 to every digit of 5 or more
    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd_digits_reg[4*k +: 4] >= 4'd5)
                bcd_adj[4*k +: 4] = bcd_digits_reg[4*k +: 4] + 4'd3;
            else
                bcd_adj[4*k +: 4] = bcd_digits_reg[4*k +: 4];
        end
    end

    // Number of significant digits, at least one
    always_comb
    begin
        priority if (bcd_digits_reg[19:16] != '0) bcd_len = 3'd5;
        else if (bcd_digits_reg[15:12] != '0)     bcd_len = 3'd4;
        else if (bcd_digits_reg[11:8] != '0)      bcd_len = 3'd3;
        else if (bcd_digits_reg[7:4] != '0)       bcd_len = 3'd2;
        else                                       bcd_len = 3'd1;
    end

    // Digit still to send, most significant first
    always_comb
    begin
        unique case (digit_count_reg)
            3'd5:    cur_digit = bcd_digits_reg[19:16];
            3'd4:    cur_digit = bcd_digits_reg[15:12];
            3'd3:    cur_digit = bcd_digits_reg[11:8];
            3'd2:    cur_digit = bcd_digits_reg[7:4];
            default: cur_digit = bcd_digits_reg[3:0];
        endcase
    end

    // Current transfer of the run
    always_comb
    begin
        cur_rs   = RS_INSTR;
        cur_byte = job.byte_val;
        cur_last = 1'b1;
        unique case (job.kind)
            JOB_INIT:
            begin
                cur_last = (transfer_index_reg == INIT_LAST_IDX);
                unique case (transfer_index_reg)
                    4'd0:    cur_byte = CMD_FUNCTION_SET;
                    4'd1:    cur_byte = CMD_DISPLAY_ON;
                    default: cur_byte = CMD_CLEAR;
                endcase
            end
            JOB_SINGLE:
                cur_rs = job.rs;
            JOB_NUMBER:
            begin
                cur_rs   = RS_DATA;
                cur_byte = ASCII_ZERO + {4'd0, cur_digit};
                cur_last = (digit_count_reg <= 3'd1);
            end
            JOB_GLYPH:
            begin
                cur_last = (transfer_index_reg == GLYPH_LAST_IDX);
                priority if (transfer_index_reg == '0)
                    cur_byte = CMD_CGRAM_BASE | {2'b00, job.slot, 3'b000};
                else if (transfer_index_reg == GLYPH_ADDR_IDX)
                    cur_byte = job.address;
                else if (transfer_index_reg == GLYPH_LAST_IDX)
                begin
                    cur_rs   = RS_DATA;
                    cur_byte = {5'd0, job.slot};
                end
                else
                begin
                    cur_rs   = RS_DATA;
                    cur_byte = {3'd0, glyph_shift_reg[ROW_W-1:0]};
                end
            end
            default: cur_last = 1'b1;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!q_status.empty)
                begin
                    unique case (job.kind)
                        JOB_INIT:   state_next = BK_WAIT;
                        JOB_NUMBER: state_next = BK_CONVERT;
                        default:    state_next = BK_PULSE;
                    endcase
                end
            BK_WAIT:
                if (delay_counter_reg == '0)
                    state_next = BK_PULSE;
            BK_CONVERT:
                if (conv_count_reg == '0)
                    state_next = BK_PULSE;
            BK_PULSE:
                if (delay_counter_reg <= CFG_W'(1))
                    state_next = BK_PUSH;
            BK_PUSH:
                if (out_free)
                    state_next = cur_last ? BK_IDLE : BK_PULSE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Counters and datapath
    always_comb
    begin
        delay_counter_next  = delay_counter_reg;
        transfer_index_next = transfer_index_reg;
        conv_count_next     = conv_count_reg;
        digit_count_next    = digit_count_reg;
        bin_next            = bin_reg;
        bcd_digits_next     = bcd_digits_reg;
        glyph_shift_next    = glyph_shift_reg;
        out_valid_next      = out_valid_reg;
        if (xfer.ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;

        unique case (state_reg)
            BK_IDLE:
            begin
                transfer_index_next = '0;
                bin_next            = job.number;
                bcd_digits_next     = '0;
                conv_count_next     = CONV_W'(NUM_W);
                glyph_shift_next    = job.rows;
                delay_counter_next  = (job.kind == JOB_INIT) ? startup_wait_reg : pulse_len;
            end
            BK_WAIT:
                if (delay_counter_reg == '0)
                    delay_counter_next = pulse_len;
                else
                    delay_counter_next = delay_counter_reg - 1'b1;
            BK_CONVERT:
                if (conv_count_reg == '0)
                begin
                    digit_count_next   = bcd_len;
                    delay_counter_next = pulse_len;
                end
                else
                begin
                    bcd_digits_next = {bcd_adj[BCD_W-2:0], bin_reg[NUM_W-1]};
                    bin_next        = {bin_reg[NUM_W-2:0], 1'b0};
                    conv_count_next = conv_count_reg - 1'b1;
                end
            BK_PULSE:
                if (delay_counter_reg > CFG_W'(1))
                    delay_counter_next = delay_counter_reg - 1'b1;
            BK_PUSH:
                if (out_load && !cur_last)
                begin
                    transfer_index_next = transfer_index_reg + 1'b1;
                    delay_counter_next  = pulse_len;
                    if (job.kind == JOB_NUMBER)
                        digit_count_next = digit_count_reg - 1'b1;
                    if (job.kind == JOB_GLYPH && transfer_index_reg != '0
                        && transfer_index_reg < GLYPH_ADDR_IDX)
                        glyph_shift_next = glyph_shift_reg >> ROW_W;
                end
            default: ;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= BK_IDLE;
            startup_wait_reg   <= STARTUP_WAIT_RESET;
            enable_pulse_reg   <= ENABLE_PULSE_RESET;
            delay_counter_reg  <= '0;
            transfer_index_reg <= '0;
            conv_count_reg     <= '0;
            digit_count_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            delay_counter_reg  <= delay_counter_next;
            transfer_index_reg <= transfer_index_next;
            conv_count_reg     <= conv_count_next;
            digit_count_reg    <= digit_count_next;
            out_valid_reg      <= out_valid_next;
            if (cfg.valid && cfg.index == CFG_STARTUP_WAIT)
                startup_wait_reg <= cfg.data;
            if (cfg.valid && cfg.index == CFG_ENABLE_PULSE)
                enable_pulse_reg <= cfg.data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bin_reg         <= bin_next;
        bcd_digits_reg  <= bcd_digits_next;
        glyph_shift_reg <= glyph_shift_next;
        if (out_load)
        begin
            out_rs_reg   <= cur_rs;
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

endmodule

/* src/char_lcd_write_controller.sv */
// Top level of the character LCD write controller.
//
//  Port   Dir   Moves                     Payload
//  req    in    one request               mode, byte_value, line_row, column,
//                                         number_value, glyph_slot, glyph_rows
//  xfer   out   one bus transfer          reg_select, bus_byte, last_of_run
//  cfg    in    one register write        index, data (always ready)
//
// Each transfer is paced by the enable strobe counter in the sequencer, which
// counts down the enable_pulse register (zero acts as one), and each request passes
// through the idle state to pick up its job. An init run first waits out the startup
// wait register; a decimal number first goes through bit-serial BCD conversion.
// A two-entry job queue lets requests be taken while a run is in progress; a
// stalled xfer channel holds the sequencer at its output register.
// Reset is asynchronous and active low; config registers return to defaults.
module char_lcd_write_controller #(
    parameter int unsigned LINE_LENGTH = 40
) (
    input  logic  clk,
    input  logic  rst_n,
    lcdw_req_if.sink    req,
    lcdw_xfer_if.source xfer,
    lcdw_cfg_if.sink    cfg
);
    import lcdw_pkg::*;

    logic      push;
    logic      pop;
    job_t      push_entry;
    job_t      head;
    q_status_t q_status;

    lcdw_front #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_front (
        .req      (req),
        .q_status (q_status),
        .push     (push),
        .entry    (push_entry)
    );

    lcdw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    lcdw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .job      (head),
        .q_status (q_status),
        .pop      (pop),
        .xfer     (xfer)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the character LCD write controller transfer stream.
`timescale 1ns / 1ps

module tb_top;
    import lcdw_pkg::*;

    localparam int LINE_LEN = 40;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  byte_value;
        logic        line_row;
        logic [5:0]  column;
        logic [15:0] number_value;
        logic [2:0]  glyph_slot;
        logic [39:0] glyph_rows;
    } lcd_req_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus_byte;
        logic       last_of_run;
    } lcd_xfer_t;

    // Directed row: either hand-written transfers or left to the predictor
    typedef struct packed {
        lcd_req_t        req;
        logic            by_model;
        logic [1:0]      n_typed;
        lcd_xfer_t [0:2] typed;
    } dir_row_t;

    // One stretch of random traffic under one register setting
    typedef struct packed {
        logic [CFG_W-1:0] startup;
        logic [CFG_W-1:0] pulse;
        logic [6:0]       send_pct;
        logic [6:0]       recv_pct;
        logic [7:0]       n_items;
        logic             allow_init;
    } phase_t;

    localparam lcd_xfer_t NO_X = '0;
    localparam int N_DIR = 21;
    localparam int N_PHASES = 5;

    logic clk = 1'b0;
    logic rst_n;

    lcdw_req_if  req_ch ();
    lcdw_xfer_if xfer_ch ();
    lcdw_cfg_if  cfg_ch ();

    char_lcd_write_controller #(
        .LINE_LENGTH (LINE_LEN)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .xfer  (xfer_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state: register copies and latched values
    logic [CFG_W-1:0] startup_cfg = STARTUP_WAIT_RESET;
    logic [CFG_W-1:0] pulse_cfg   = ENABLE_PULSE_RESET;
    logic [7:0]       latched_addr = '0;
    logic [2:0]       latched_slot = '0;
    int               run_length = 0;

    lcd_xfer_t pending_xfers [$];
    int        mismatch_count = 0;
    int        xfer_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    // Directed requests: extremes, every mode, saturation, ignored modes
    dir_row_t directed_rows [N_DIR] = '{
        '{'{MODE_INIT, 8'h00, 1'b0, 6'd0, 16'd0, 3'd0, 40'd0}, 1'b0, 2'd3,
          '{'{RS_INSTR, CMD_FUNCTION_SET, 1'b0}, '{RS_INSTR, CMD_DISPLAY_ON, 1'b0},
            '{RS_INSTR, CMD_CLEAR, 1'b1}}},
        '{'{MODE_COMMAND, 8'h00, 1'b0, 6'd0, 16'd0, 3'd0, 40'd0}, 1'b0, 2'd1,
          '{'{RS_INSTR, 8'h00, 1'b1}, NO_X, NO_X}},
        '{'{MODE_COMMAND, 8'hFF, 1'b1, 6'h3F, 16'hFFFF, 3'h7, 40'hFF_FFFF_FFFF}, 1'b0, 2'd1,
          '{'{RS_INSTR, 8'hFF, 1'b1}, NO_X, NO_X}},
        '{'{MODE_DATA, 8'h00, 1'b0, 6'd0, 16'd0, 3'd0, 40'd0}, 1'b0, 2'd1,
          '{'{RS_DATA, 8'h00, 1'b1}, NO_X, NO_X}},
        '{'{MODE_DATA, 8'hFF, 1'b0, 6'd0, 16'd0, 3'd0, 40'd0}, 1'b0, 2'd1,
          '{'{RS_DATA, 8'hFF, 1'b1}, NO_X, NO_X}},
        '{'{MODE_DATA, 8'h5A, 1'b1, 6'h3F, 16'hFFFF, 3'h7, 40'hFF_FFFF_FFFF}, 1'b1, 2'd0,
          '{NO_X, NO_X, NO_X}},
        '{'{MODE_CURSOR, 8'h00, 1'b0, 6'd0, 16'd0, 3'd0, 40'd0}, 1'b0, 2'd1,
          '{'{RS_INSTR, 8'h80, 1'b1}, NO_X, NO_X}},
        '{'{MODE_CURSOR, 8'h00, 1'b1, 6'd39, 16'd0, 3'd0, 40'd0}, 1'b0, 2'd1,
          '{'{RS_INSTR, 8'hE7, 1'b1}, NO_X, NO_X}},
        // column past the line end saturates to the last column
        '{'{MODE_CURSOR, 8'h00, 1'b0, 6'd40, 16'd0, 3'd0, 40'd0}, 1'b0, 2'd1,
          '{'{RS_INSTR, 8'hA7, 1'b1}, NO_X, NO_X}},
        '{'{MODE_CURSOR, 8'hFF, 1'b1, 6'h3F, 16'hFFFF, 3'h7, 40'hFF_FFFF_FFFF}, 1'b0, 2'd1,
          '{'{RS_INSTR, 8'hE7, 1'b1}, NO_X, NO_X}},
        // zero prints a single digit
        '{'{MODE_NUMBER, 8'h00, 1'b0, 6'd0, 16'd0, 3'd0, 40'd0}, 1'b0, 2'd1,
          '{'{RS_DATA, 8'h30, 1'b1}, NO_X, NO_X}},
        '{'{MODE_NUMBER, 8'h00, 1'b0, 6'd0, 16'd9, 3'd0, 40'd0}, 1'b0, 2'd1,
          '{'{RS_DATA, 8'h39, 1'b1}, NO_X, NO_X}},
        '{'{MODE_NUMBER, 8'h00, 1'b0, 6'd0, 16'd10, 3'd0, 40'd0}, 1'b1, 2'd0,
          '{NO_X, NO_X, NO_X}},
        '{'{MODE_NUMBER, 8'h00, 1'b0, 6'd0, 16'd10000, 3'd0, 40'd0}, 1'b1, 2'd0,
          '{NO_X, NO_X, NO_X}},
        '{'{MODE_NUMBER, 8'hFF, 1'b1, 6'h3F, 16'hFFFF, 3'h7, 40'hFF_FFFF_FFFF}, 1'b1, 2'd0,
          '{NO_X, NO_X, NO_X}},
        '{'{MODE_GLYPH, 8'h00, 1'b0, 6'd0, 16'd0, 3'd0, 40'd0}, 1'b1, 2'd0,
          '{NO_X, NO_X, NO_X}},
        '{'{MODE_GLYPH, 8'hFF, 1'b1, 6'd39, 16'hFFFF, 3'h7, 40'hFF_FFFF_FFFF}, 1'b1, 2'd0,
          '{NO_X, NO_X, NO_X}},
        '{'{MODE_GLYPH, 8'h00, 1'b0, 6'd45, 16'd0, 3'd2, 40'hAA_AAAA_AAAA}, 1'b1, 2'd0,
          '{NO_X, NO_X, NO_X}},
        // unused modes make no transfer at all
        '{'{MODE_UNUSED_LO, 8'h5A, 1'b1, 6'd7, 16'h1234, 3'd5, 40'h12_3456_789A}, 1'b0, 2'd0,
          '{NO_X, NO_X, NO_X}},
        '{'{MODE_UNUSED_HI, 8'hFF, 1'b1, 6'h3F, 16'hFFFF, 3'h7, 40'hFF_FFFF_FFFF}, 1'b0, 2'd0,
          '{NO_X, NO_X, NO_X}},
        '{'{MODE_NUMBER, 8'h00, 1'b0, 6'd0, 16'd12345, 3'd0, 40'd0}, 1'b1, 2'd0,
          '{NO_X, NO_X, NO_X}}
    };

    // Random phases; startup wait at maximum allows no init, pulse at maximum runs nothing
    phase_t phases [N_PHASES] = '{
        '{24'd0,   24'd1,   7'd0,  7'd0,  8'd20, 1'b1},
        '{CFG_MAX, 24'd3,   7'd74, 7'd0,  8'd15, 1'b0},
        '{24'd7,   CFG_MAX, 7'd0,  7'd0,  8'd0,  1'b1},
        '{24'd0,   24'd0,   7'd0,  7'd74, 8'd20, 1'b1},
        '{24'd12,  24'd5,   7'd31, 7'd31, 8'd25, 1'b1}
    };

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void add_xfer(input logic rs, input logic [7:0] b);
        lcd_xfer_t x;
        x.rs = rs;
        x.bus_byte = b;
        x.last_of_run = 1'b0;
        pending_xfers.push_back(x);
    endfunction

    // Append the whole transfer run of one request to the expected stream
    function automatic void plan_transfers(input lcd_req_t r);
        logic [3:0] digs [5];
        logic [7:0] addr;
        int unsigned v;
        int cnt;
        int col;
        int first;
        first = pending_xfers.size();
        col = (r.column >= LINE_LEN) ? LINE_LEN - 1 : int'(r.column);
        addr = (r.line_row ? DDRAM_LINE1 : DDRAM_LINE0) + 8'(col);
        case (r.mode)
            MODE_INIT:
            begin
                add_xfer(RS_INSTR, CMD_FUNCTION_SET);
                add_xfer(RS_INSTR, CMD_DISPLAY_ON);
                add_xfer(RS_INSTR, CMD_CLEAR);
            end
            MODE_COMMAND: add_xfer(RS_INSTR, r.byte_value);
            MODE_DATA:    add_xfer(RS_DATA, r.byte_value);
            MODE_CURSOR:
            begin
                latched_addr = addr;
                add_xfer(RS_INSTR, addr);
            end
            MODE_NUMBER:
            begin
                v = r.number_value;
                cnt = 0;
                do
                begin
                    digs[cnt] = 4'(v % 10);
                    v = v / 10;
                    cnt++;
                end while (v != 0 && cnt < BCD_DIGITS);
                for (int i = cnt - 1; i >= 0; i--)
                    add_xfer(RS_DATA, ASCII_ZERO + 8'(digs[i]));
            end
            MODE_GLYPH:
            begin
                latched_slot = r.glyph_slot;
                latched_addr = addr;
                // CGRAM address: slot times eight rows
                add_xfer(RS_INSTR, CMD_CGRAM_BASE | {2'b00, r.glyph_slot, 3'b000});
                for (int i = 0; i < GLYPH_ROWS; i++)
                    add_xfer(RS_DATA, {3'b000, r.glyph_rows[ROW_W*i +: ROW_W]});
                add_xfer(RS_INSTR, addr);
                add_xfer(RS_DATA, {5'b00000, r.glyph_slot});
            end
            default: return;
        endcase
        pending_xfers[pending_xfers.size() - 1].last_of_run = 1'b1;
        run_length = pending_xfers.size() - first;
    endfunction

    function automatic lcd_req_t random_request(input logic allow_init);
        lcd_req_t r;
        int digits;
        int lo;
        int hi;
        if ($urandom_range(99) < 8)
            r.mode = $urandom_range(1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
        else
        begin
            r.mode = 3'($urandom_range(MODE_INIT, MODE_GLYPH));
            if (!allow_init && r.mode == MODE_INIT)
                r.mode = MODE_COMMAND;
        end
        r.byte_value = 8'($urandom_range(255));
        r.line_row = 1'($urandom_range(1));
        // mostly in-range columns, some past the line end
        if ($urandom_range(99) < 80)
            r.column = 6'($urandom_range(LINE_LEN - 1));
        else
            r.column = 6'($urandom_range(63, LINE_LEN));
        // spread numbers evenly over digit counts
        digits = $urandom_range(BCD_DIGITS - 1);
        lo = (digits == 0) ? 0 : 10 ** digits;
        hi = (digits == BCD_DIGITS - 1) ? 65535 : 10 ** (digits + 1) - 1;
        r.number_value = 16'($urandom_range(hi, lo));
        r.glyph_slot = 3'($urandom_range(GLYPH_SLOTS - 1));
        r.glyph_rows = {8'($urandom_range(255)), 32'($urandom)};
        return r;
    endfunction

    // Cycles to let the block settle once nothing is expected
    function automatic int quiet_cycles();
        int p;
        int s;
        p = (pulse_cfg > 64) ? 64 : int'(pulse_cfg);
        s = (startup_cfg > 64) ? 64 : int'(startup_cfg);
        return 40 + 2 * p + s;
    endfunction

    // Drive one request, with a random gap first, until it is taken
    task automatic offer_request(input lcd_req_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.mode         <= r.mode;
        req_ch.byte_value   <= r.byte_value;
        req_ch.line_row     <= r.line_row;
        req_ch.column       <= r.column;
        req_ch.number_value <= r.number_value;
        req_ch.glyph_slot   <= r.glyph_slot;
        req_ch.glyph_rows   <= r.glyph_rows;
        req_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    task automatic wait_for_quiet();
        req_ch.valid <= 1'b0;
        while (pending_xfers.size() != 0)
            @(posedge clk);
        repeat (quiet_cycles()) @(posedge clk);
    endtask

    // Write both registers back to back; valid stays high between them
    task automatic apply_settings(input logic [CFG_W-1:0] startup,
                                  input logic [CFG_W-1:0] pulse);
        cfg_ch.index <= CFG_STARTUP_WAIT;
        cfg_ch.data  <= startup;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        startup_cfg = startup;
        cfg_ch.index <= CFG_ENABLE_PULSE;
        cfg_ch.data  <= pulse;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        pulse_cfg = pulse;
        cfg_ch.valid <= 1'b0;
    endtask

    // Transfer checker and random stall on the output side
    always @(posedge clk)
    begin
        lcd_xfer_t want;
        if (rst_n === 1'b1 && xfer_ch.valid && xfer_ch.ready)
        begin
            if (pending_xfers.size() == 0)
                flag_mismatch($sformatf("transfer %0d unexpected: rs=%0b byte=%02h last=%0b",
                              xfer_count, xfer_ch.reg_select, xfer_ch.bus_byte,
                              xfer_ch.last_of_run));
            else
            begin
                want = pending_xfers.pop_front();
                if (xfer_ch.reg_select !== want.rs)
                    flag_mismatch($sformatf("transfer %0d reg_select got %0b want %0b",
                                  xfer_count, xfer_ch.reg_select, want.rs));
                if (xfer_ch.bus_byte !== want.bus_byte)
                    flag_mismatch($sformatf("transfer %0d bus_byte got %02h want %02h",
                                  xfer_count, xfer_ch.bus_byte, want.bus_byte));
                if (xfer_ch.last_of_run !== want.last_of_run)
                    flag_mismatch($sformatf("transfer %0d last_of_run got %0b want %0b",
                                  xfer_count, xfer_ch.last_of_run, want.last_of_run));
            end
            xfer_count++;
        end
        if (rst_n !== 1'b1)
            xfer_ch.ready <= 1'b0;
        else
            xfer_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Main sequence: reset, directed table, random phases, final check
    initial
    begin
        phase_t   ph;
        lcd_req_t rq;
        int       sent;
        logic     paused;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_INIT;
        req_ch.byte_value   <= '0;
        req_ch.line_row     <= 1'b0;
        req_ch.column       <= '0;
        req_ch.number_value <= '0;
        req_ch.glyph_slot   <= '0;
        req_ch.glyph_rows   <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_STARTUP_WAIT;
        cfg_ch.data         <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // short timings so runs finish quickly
        apply_settings(24'd5, 24'd2);
        for (int i = 0; i < N_DIR; i++)
        begin
            offer_request(directed_rows[i].req);
            if (directed_rows[i].by_model)
                plan_transfers(directed_rows[i].req);
            else
                for (int k = 0; k < directed_rows[i].n_typed; k++)
                    pending_xfers.push_back(directed_rows[i].typed[k]);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            ph = phases[p];
            wait_for_quiet();
            apply_settings(ph.startup, ph.pulse);
            send_idle_pct = ph.send_pct;
            recv_stall_pct = ph.recv_pct;
            sent = 0;
            paused = 1'b0;
            while (sent < ph.n_items)
            begin
                // halfway through, hold off until the output side drains
                if (!paused && sent == ph.n_items / 2)
                begin
                    wait_for_quiet();
                    paused = 1'b1;
                end
                rq = random_request(ph.allow_init);
                offer_request(rq);
                plan_transfers(rq);
                if (rq.mode <= MODE_GLYPH)
                    sent++;
            end
        end

        wait_for_quiet();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hang guard
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
